// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Payload structs, status and command codes, the cell command and result
// structs, and the geometry of the bitmap held in the cell row.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NumBlocks   = 4096;
  localparam int GrantRange  = 4096;
  localparam int BlkLimitMax = (NumBlocks < GrantRange) ? NumBlocks : GrantRange;

  localparam int BlkIdW   = 12;                 // block number width
  localparam int BlkCntW  = 13;                 // block count width
  localparam int WordBits = 64;                 // bits held in one cell
  localparam int BitW     = 6;                  // bit index inside a cell
  localparam int WordW    = BlkIdW - BitW;      // cell index width
  localparam int NumWords = (BlkLimitMax + WordBits - 1) / WordBits;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgFirstDataBlock = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBlockCount     = CfgIdxW'(1);

  localparam logic [BlkIdW-1:0]  FdbReset     = BlkIdW'(64);
  localparam logic [BlkCntW-1:0] BlkCntReset  = BlkCntW'(4096);
  localparam logic [BlkCntW-1:0] BlkLimitCap  = BlkCntW'(BlkLimitMax);

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoneFree = 2'd1;
  localparam logic [1:0] StInvalid  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [BlkIdW-1:0] block_id;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BlkIdW-1:0] granted_block;
  } bba_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               start;
    logic [WordW-1:0]   start_word;
    logic               clr;
    logic [WordW-1:0]   clr_word;
    logic [BitW-1:0]    clr_bit;
    logic [BlkIdW-1:0]  fdb;
    logic [BlkCntW-1:0] lim;
  } bba_cmd_t;

  // answer of the cell that holds the search token
  typedef struct packed {
    logic              hit;
    logic              none;
    logic [BlkIdW-1:0] grant;
  } bba_res_t;

endpackage

// ===== rtl/bba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cell: one 64-block slice of the used/free bitmap
// Holds one bitmap word. When the search token sits here, finds the lowest
// free block inside the allowed window, marks it used, or hands the token on.
// ----------------------------------------------------------------------------
module bba_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bba_pkg::WordW-1:0] cell_idx_i,
  input  bba_pkg::bba_cmd_t         cmd_i,
  input  logic                     tok_i,
  output logic                     tok_o,
  output bba_pkg::bba_res_t         res_o
);

  logic [bba_pkg::WordBits-1:0] word_q, word_d;
  logic                         tok_q, tok_d;
  logic [bba_pkg::WordBits-1:0] lo_mask, hi_mask, cand, set_mask;
  logic [bba_pkg::BitW-1:0]     sel_bit;
  logic                         any_free;
  logic [bba_pkg::WordW-1:0]    fdb_word, lim_word_lo;
  logic                         lim_word_hi;
  logic [bba_pkg::WordW:0]      lim_word, idx_ext, next_idx;
  logic [bba_pkg::BlkCntW-1:0]  next_base;

  assign fdb_word    = cmd_i.fdb[bba_pkg::BlkIdW-1:bba_pkg::BitW];
  assign lim_word_lo = cmd_i.lim[bba_pkg::BlkCntW-2:bba_pkg::BitW];
  assign lim_word_hi = cmd_i.lim[bba_pkg::BlkCntW-1];
  assign lim_word    = {lim_word_hi, lim_word_lo};
  assign idx_ext     = {1'b0, cell_idx_i};
  assign next_idx    = idx_ext + (bba_pkg::WordW+1)'(1);
  assign next_base   = {next_idx, {bba_pkg::BitW{1'b0}}};

  always_comb begin
    if (cell_idx_i > fdb_word) begin
      lo_mask = '1;
    end else if (cell_idx_i == fdb_word) begin
      lo_mask = {bba_pkg::WordBits{1'b1}} << cmd_i.fdb[bba_pkg::BitW-1:0];
    end else begin
      lo_mask = '0;
    end
    if (idx_ext < lim_word) begin
      hi_mask = '1;
    end else if (idx_ext == lim_word) begin
      hi_mask = ~({bba_pkg::WordBits{1'b1}} << cmd_i.lim[bba_pkg::BitW-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand     = ~word_q & lo_mask & hi_mask;
  assign any_free = |cand;

  // lowest free bit wins
  always_comb begin
    sel_bit = '0;
    for (int j = bba_pkg::WordBits - 1; j >= 0; j--) begin
      if (cand[j]) begin
        sel_bit = bba_pkg::BitW'(j);
      end
    end
  end

  assign set_mask = {{(bba_pkg::WordBits-1){1'b0}}, 1'b1} << sel_bit;

  always_comb begin
    word_d = word_q;
    if (tok_q && any_free) begin
      word_d = word_q | set_mask;
    end
    if (cmd_i.clr && cmd_i.clr_word == cell_idx_i) begin
      word_d = word_d & ~({{(bba_pkg::WordBits-1){1'b0}}, 1'b1} << cmd_i.clr_bit);
    end
  end

  assign tok_d = tok_i || (cmd_i.start && cmd_i.start_word == cell_idx_i);

  // pass the token on while the next slice still lies below the limit
  assign tok_o = tok_q && !any_free && (next_base < cmd_i.lim);

  always_comb begin
    res_o.hit   = tok_q && any_free;
    res_o.none  = tok_q && !any_free && !(next_base < cmd_i.lim);
    res_o.grant = res_o.hit ? {cell_idx_i, sel_bit} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      word_q <= word_d;
      tok_q  <= tok_d;
    end
  end

endmodule

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl: request sequencer and result register
// Takes requests, checks ranges, starts the token search in the cell row,
// collects the answer and holds it in the output register.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bba_pkg::bba_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bba_pkg::bba_out_t               out_data_o,
  input  logic [bba_pkg::BlkIdW-1:0]      fdb_i,
  input  logic [bba_pkg::BlkCntW-1:0]     lim_i,
  output bba_pkg::bba_cmd_t               cmd_o,
  input  bba_pkg::bba_res_t               res_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  bba_pkg::bba_out_t pend_q;
  bba_pkg::bba_out_t out_q;
  logic              out_valid_q;
  logic              accept;
  logic              id_bad, win_empty;
  logic              load_out;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign id_bad      = {1'b0, in_data_i.block_id} >= lim_i;
  assign win_empty   = {1'b0, fdb_i} >= lim_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // hold until the output register is free
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o.fdb        = fdb_i;
    cmd_o.lim        = lim_i;
    cmd_o.start      = accept && (in_data_i.cmd == bba_pkg::CmdAlloc) && !win_empty;
    cmd_o.start_word = fdb_i[bba_pkg::BlkIdW-1:bba_pkg::BitW];
    cmd_o.clr        = accept && (in_data_i.cmd == bba_pkg::CmdFree) && !id_bad;
    cmd_o.clr_word   = in_data_i.block_id[bba_pkg::BlkIdW-1:bba_pkg::BitW];
    cmd_o.clr_bit    = in_data_i.block_id[bba_pkg::BitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_q       <= pend_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pend_q.granted_block <= '0;
            if (in_data_i.cmd == bba_pkg::CmdFree) begin
              pend_q.status <= id_bad ? bba_pkg::StInvalid : bba_pkg::StOk;
              state_q       <= ST_DONE;
            end else if (win_empty) begin
              pend_q.status <= bba_pkg::StNoneFree;
              state_q       <= ST_DONE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (res_i.hit) begin
            pend_q.status        <= bba_pkg::StOk;
            pend_q.granted_block <= res_i.grant;
            state_q              <= ST_DONE;
          end else if (res_i.none) begin
            pend_q.status        <= bba_pkg::StNoneFree;
            pend_q.granted_block <= '0;
            state_q              <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit block allocator over a used/free bitmap
// Allocate hands out the lowest free block from first_data_block up to the
// block limit; free clears the bit of the named block.
// ----------------------------------------------------------------------------
// The bitmap lives in a row of 64 cells of 64 bits each, all free after
// reset. A free clears its bit as it is taken; its result goes through the
// pending register to the output register. An allocate starts a search token
// in the cell that holds first_data_block; the token moves one cell per cycle
// until a cell finds a free bit in the window or no cell below the limit is
// left. One request is in flight at a time; a finished result waits in the
// output register while the next request is taken. Configuration writes are
// always ready and must only come while no request is in flight.
module bitmap_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bba_pkg::bba_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bba_pkg::bba_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bba_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [bba_pkg::BlkIdW-1:0]  fdb_q;
  logic [bba_pkg::BlkCntW-1:0] blk_cnt_q;
  logic [bba_pkg::BlkCntW-1:0] lim;
  bba_pkg::bba_cmd_t           cmd;
  bba_pkg::bba_res_t           cell_res [bba_pkg::NumWords];
  logic                        tok [bba_pkg::NumWords+1];
  bba_pkg::bba_res_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q     <= bba_pkg::FdbReset;
      blk_cnt_q <= bba_pkg::BlkCntReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bba_pkg::CfgFirstDataBlock) begin
        fdb_q <= cfg_data_i[bba_pkg::BlkIdW-1:0];
      end else if (cfg_index_i == bba_pkg::CfgBlockCount) begin
        blk_cnt_q <= cfg_data_i[bba_pkg::BlkCntW-1:0];
      end
    end
  end

  assign lim = (blk_cnt_q > bba_pkg::BlkLimitCap) ? bba_pkg::BlkLimitCap : blk_cnt_q;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .fdb_i       (fdb_q),
    .lim_i       (lim),
    .cmd_o       (cmd),
    .res_i       (res)
  );

  assign tok[0] = 1'b0;

  for (genvar k = 0; k < bba_pkg::NumWords; k++) begin : g_cell
    bba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (bba_pkg::WordW'(k)),
      .cmd_i      (cmd),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1]),
      .res_o      (cell_res[k])
    );
  end

  // only the cell holding the token answers, so an OR merges the answers
  always_comb begin
    res = '0;
    for (int k = 0; k < bba_pkg::NumWords; k++) begin
      res = res | cell_res[k];
    end
  end

endmodule
